// ----- src/multicart_outer_bank_mapper_top_defines.svh -----
// Assertion macros used by the multicart outer bank mapper top level.
`ifndef MULTICART_OUTER_BANK_MAPPER_TOP_DEFINES_SVH
`define MULTICART_OUTER_BANK_MAPPER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while rst is high.
`define MOBM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst is high.
`define MOBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/mobm_pkg.sv -----
// Types and constants shared by the multicart outer bank mapper modules.
`timescale 1ns / 1ps

package mobm_pkg;

  localparam int unsigned REG_W       = 8;
  localparam int unsigned NUM_REGS    = 4;
  localparam int unsigned IDX_W       = 2;
  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned BANK_W      = 12;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned OPCODE_W    = 2;

  // Stream widths: request tdata = {value, addr}, result tdata = {pad, slot, bank}
  localparam int unsigned S_TDATA_W   = 24;
  localparam int unsigned S_TUSER_W   = OPCODE_W;
  localparam int unsigned M_TDATA_W   = 24;
  localparam int unsigned M_TUSER_W   = 1;

  localparam int unsigned LOCK_BIT    = 6;
  localparam int unsigned CHR_MASK_EN = 3;
  localparam logic [SLOT_W-1:0] PRG_SLOT_BASE = 6'd4;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE = 2'd0,
    OP_PRG   = 2'd1,
    OP_CHR   = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  // Outer register file as seen by the translation logic.
  typedef struct packed {
    logic [REG_W-1:0] r3;
    logic [REG_W-1:0] r2;
    logic [REG_W-1:0] r1;
    logic [REG_W-1:0] r0;
  } outer_regs_t;

  typedef struct packed {
    logic [BANK_W-1:0] bank;
    logic [SLOT_W-1:0] slot;
    logic              taken;
  } xlate_res_t;

endpackage

// ----- src/mobm_xlate.sv -----
// Bank translation and write-lock decode for one request.
`timescale 1ns / 1ps

module mobm_xlate (
  input  mobm_pkg::opcode_t                 opcode,
  input  logic [mobm_pkg::ADDR_W-1:0]       addr,
  input  logic [mobm_pkg::REG_W-1:0]        value,
  input  mobm_pkg::outer_regs_t             regs,
  output mobm_pkg::xlate_res_t              res
);
  import mobm_pkg::*;

  logic [5:0]       prg_keep;
  logic [REG_W-1:0] prg_bank;
  logic [3:0]       chr_shamt;
  logic [REG_W:0]   chr_mask_w;
  logic [REG_W-1:0] chr_inner;
  logic [REG_W-1:0] chr_low;

  // PRG: keep bits not claimed by register 3, then OR in register 1
  assign prg_keep = ~regs.r3[5:0];
  assign prg_bank = {2'b00, value[5:0] & prg_keep} | regs.r1;

  // CHR: mask to 2^(n+1) entries when bit 3 of register 2 is set, clear when register 2 is otherwise nonzero, else pass
  assign chr_shamt  = {1'b0, regs.r2[2:0]} + 4'd1;
  assign chr_mask_w = (9'd1 << chr_shamt) - 9'd1;

  always_comb begin
    if (regs.r2[CHR_MASK_EN]) begin
      chr_inner = value & chr_mask_w[REG_W-1:0];
    end else if (regs.r2 != '0) begin
      chr_inner = '0;
    end else begin
      chr_inner = value;
    end
  end

  assign chr_low = chr_inner | regs.r0;

  always_comb begin
    res = '0;
    case (opcode)
      OP_WRITE: begin
        res.taken = ~regs.r3[LOCK_BIT];
      end
      OP_PRG: begin
        res.bank = {4'b0000, prg_bank};
        res.slot = {3'b000, addr[15:13]} + PRG_SLOT_BASE;
      end
      OP_CHR: begin
        res.bank = {regs.r2[7:4], chr_low};
        res.slot = addr[15:10];
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

// ----- src/multicart_outer_bank_mapper_top.sv -----
// Top level of the multicart outer bank mapper: request register, translation, result register.
`timescale 1ns / 1ps

// Multicart outer bank mapper. Each request is a register write (opcode 0), a PRG bank
// translation (opcode 1) or a CHR bank translation (opcode 2); opcode 3 changes nothing
// and returns zeros. Every request gives exactly one result. The block takes one request
// per cycle while the result side does not stall; each request passes through the request
// register, then through the translation logic into the result register. A request that
// follows a write sees the register the write stored. Writes fill outer registers 0..3 in
// turn through a 2-bit rotating index; once bit 6 of register 3 is set, writes are
// dropped (write_taken 0) until reset. A stalled result stalls the request register,
// which then deasserts s_axis_tready.
`include "multicart_outer_bank_mapper_top_defines.svh"

module multicart_outer_bank_mapper_top (
  input  logic                              clk,
  input  logic                              rst,
  // request side
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [mobm_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // addr[15:0], value[23:16]
  input  logic [mobm_pkg::S_TUSER_W-1:0]    s_axis_tuser,  // opcode[1:0]
  // result side
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [mobm_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // bank[11:0], slot[17:12], 0[23:18]
  output logic [mobm_pkg::M_TUSER_W-1:0]    m_axis_tuser   // write_taken[0]
);
  import mobm_pkg::*;

  // Request register
  logic              s1_valid;
  opcode_t           s1_op;
  logic [ADDR_W-1:0] s1_addr;
  logic [REG_W-1:0]  s1_value;
  logic              s1_advance;

  // Result register
  logic              out_valid;
  logic [BANK_W-1:0] out_bank;
  logic [SLOT_W-1:0] out_slot;
  logic              out_taken;

  // Outer registers and rotating write index
  logic [REG_W-1:0]  outer_regs [NUM_REGS];
  logic [IDX_W-1:0]  write_index;
  logic [IDX_W-1:0]  write_index_next;

  outer_regs_t       regs_view;
  xlate_res_t        res;
  logic              reg_write;

  // Move the request on when the result register is free or being emptied
  assign s1_advance    = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  // Capture payload on every accepted request
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_op    <= opcode_t'(s_axis_tuser[OPCODE_W-1:0]);
      s1_addr  <= s_axis_tdata[ADDR_W-1:0];
      s1_value <= s_axis_tdata[ADDR_W +: REG_W];
    end
  end

  assign regs_view = '{r3: outer_regs[3], r2: outer_regs[2],
                       r1: outer_regs[1], r0: outer_regs[0]};

  mobm_xlate u_xlate (
    .opcode (s1_op),
    .addr   (s1_addr),
    .value  (s1_value),
    .regs   (regs_view),
    .res    (res)
  );

  // Store the byte only when the request leaves the request register unlocked
  assign reg_write        = s1_advance && res.taken;
  assign write_index_next = write_index + 2'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        outer_regs[i] <= '0;
      end
      write_index <= '0;
    end else if (reg_write) begin
      outer_regs[write_index] <= s1_value;
      write_index             <= write_index_next;
    end
  end

  // Result register: hold while stalled, load on advance, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_bank  <= res.bank;
      out_slot  <= res.slot;
      out_taken <= res.taken;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(M_TDATA_W - BANK_W - SLOT_W){1'b0}}, out_slot, out_bank};
  assign m_axis_tuser  = out_taken;

  // A locked write must leave a result that reports nothing stored
  `MOBM_ASSERT_NEXT(a_locked_write_dropped,
    s1_advance && (s1_op == OP_WRITE) && outer_regs[3][LOCK_BIT],
    !out_taken, "locked write reported as stored")

  // A stored write advances the rotating index by one
  `MOBM_ASSERT_NEXT(a_index_advances, reg_write,
    write_index == 2'($past(write_index) + 2'd1), "write index did not advance")

  // A stored write result carries no bank or slot
  `MOBM_ASSERT_NOW(a_write_result_zero, out_valid && out_taken,
    (out_bank == '0) && (out_slot == '0), "write result has nonzero bank or slot")

  // Once locked, the lock stays until reset
  `MOBM_ASSERT_NEXT(a_lock_sticky, outer_regs[3][LOCK_BIT],
    outer_regs[3][LOCK_BIT], "write lock cleared without reset")

endmodule
